FILE: design/pwbp_pkg.sv
// ---------------------------------------------------------------------------
// Pulse width bit packer package
// Shared word types, window constants and the queue entry layout.
// ---------------------------------------------------------------------------
package pwbp_pkg;

   // Slots in one serial frame window, start and stop slot included.
   localparam int unsigned WINDOW_SLOTS = 10;
   localparam logic [9:0] WINDOW_ONES = 10'h3FF;

   // Depth of the queue between the front and the back.
   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   // Input word.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
   } req_word_type;

   // Result word.
   typedef struct packed {
      logic [7:0] serial_byte;
      logic       item_last;
      logic       final_flush;
   } rsp_word_type;

   // Classified input word as it waits in the queue. need_left[k] is the
   // number of slots that the bits after bit pair k still need.
   typedef struct packed {
      logic [7:0]      data_byte;
      logic            stream_end;
      logic [2:0][4:0] need_left;
   } queue_entry_type;

endpackage

FILE: design/pwbp_front.sv
// ---------------------------------------------------------------------------
// Pulse width bit packer front
// Accepts input words and tags them with the slot demand of later bit pairs.
// ---------------------------------------------------------------------------
module pwbp_front (
   input  logic                     req_valid,
   output logic                     req_stall,
   input  pwbp_pkg::req_word_type   req_data,
   input  logic                     queue_full,
   output logic                     push_valid,
   output pwbp_pkg::queue_entry_type push_entry
);
   import pwbp_pkg::*;

   // The queue takes a word whenever it has room.
   assign req_stall  = queue_full;
   assign push_valid = req_valid && !queue_full;

   // A one bit needs two slots and a zero bit three. For each bit pair the
   // remaining demand of the bits above it is summed, so the back can tell
   // whether a later bit of the same word will still close a window.
   always_comb begin
      logic [4:0] sum;
      push_entry.data_byte  = req_data.data_byte;
      push_entry.stream_end = req_data.stream_end;
      for (int k = 0; k < 3; k++) begin
         sum = 5'd0;
         for (int b = 2 * k + 2; b < 8; b++) begin
            sum = sum + (req_data.data_byte[b] ? 5'd2 : 5'd3);
         end
         push_entry.need_left[k] = sum;
      end
   end

endmodule

FILE: design/pwbp_queue.sv
// ---------------------------------------------------------------------------
// Pulse width bit packer queue
// Small FIFO that decouples the front from the back.
// ---------------------------------------------------------------------------
module pwbp_queue #(
   parameter int unsigned DEPTH = pwbp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  pwbp_pkg::queue_entry_type push_entry,
   output logic                      full,
   input  logic                      pop,
   output logic                      pop_valid,
   output pwbp_pkg::queue_entry_type pop_entry
);
   import pwbp_pkg::*;

   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

   queue_entry_type   entry_ff [DEPTH];
   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   // Pointer and fill count update, pointers wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: design/pwbp_back.sv
// ---------------------------------------------------------------------------
// Pulse width bit packer back
// Packs two bits a cycle into the slot window while not stalled; drives the result.
// ---------------------------------------------------------------------------
module pwbp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      queue_valid,
   input  pwbp_pkg::queue_entry_type queue_entry,
   output logic                      queue_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output pwbp_pkg::rsp_word_type    rsp_data
);
   import pwbp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_PACK  = 3'b010,
      ST_FLUSH = 3'b100
   } back_state_type;

   typedef struct packed {
      logic       emit;
      logic [7:0] emit_byte;
      logic [9:0] window;
      logic [3:0] used;
   } bit_step_type;

   // One bit into the window. A full window is emitted first when the code
   // does not fit; the code then clears its low slots from the fill point.
   function automatic bit_step_type pack_bit(logic [9:0] window, logic [3:0] used,
                                             logic one);
      bit_step_type r;
      logic [1:0]   need;
      logic [9:0]   low_mask;
      need          = one ? 2'd2 : 2'd3;
      low_mask      = one ? 10'b01 : 10'b11;
      r.window      = window;
      r.used        = used;
      r.emit_byte   = window[8:1];
      r.emit        = ({1'b0, used} + {3'b0, need}) > 5'(WINDOW_SLOTS);
      if (r.emit) begin
         r.window = WINDOW_ONES;
         r.used   = 4'd0;
      end
      r.window = r.window & ~(low_mask << r.used);
      r.used   = r.used + {2'b0, need};
      return r;
   endfunction

   back_state_type  state_ff, state_in;
   queue_entry_type item_ff, item_in;
   logic [1:0]      step_ff, step_in;
   logic [9:0]      win_ff, win_in;
   logic [3:0]      used_ff, used_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_word_type    rsp_word_ff, rsp_word_in;

   bit_step_type    step_a;
   bit_step_type    step_b;
   logic [1:0]      pair;
   logic [4:0]      need_left;
   logic [5:0]      reach;
   logic            step_emit;
   logic [7:0]      step_byte;
   logic            step_last;
   logic            out_free;
   logic            item_done;
   logic            take;
   logic            push;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Two bits of the current pair; at most one window closes per pair.
   always_comb begin
      pair      = item_ff.data_byte[{step_ff, 1'b0} +: 2];
      step_a    = pack_bit(win_ff, used_ff, pair[0]);
      step_b    = pack_bit(step_a.window, step_a.used, pair[1]);
      step_emit = step_a.emit || step_b.emit;
      step_byte = step_a.emit ? step_a.emit_byte : step_b.emit_byte;
      need_left = (step_ff == 2'd3) ? 5'd0 : item_ff.need_left[step_ff];
      reach     = {2'b0, step_b.used} + {1'b0, need_left};
      // Last result of this word when no later bit overflows and no flush follows.
      step_last = !item_ff.stream_end && (reach <= 6'(WINDOW_SLOTS));
   end

   // A word finishes on its last pair without flush, or on its flush.
   assign item_done = out_free &&
                      (((state_ff == ST_PACK) && (step_ff == 2'd3) && !item_ff.stream_end) ||
                       (state_ff == ST_FLUSH));
   assign take      = queue_valid && ((state_ff == ST_IDLE) || item_done);
   assign queue_pop = take;

   // Sequencer and window update.
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      step_in      = step_ff;
      win_in       = win_ff;
      used_in      = used_ff;
      push         = 1'b0;
      rsp_word_in  = rsp_word_ff;
      case (state_ff)
         ST_IDLE: begin
            state_in = ST_IDLE;
         end
         ST_PACK: begin
            if (out_free) begin
               win_in  = step_b.window;
               used_in = step_b.used;
               step_in = step_ff + 2'd1;
               if (step_emit) begin
                  push                    = 1'b1;
                  rsp_word_in.serial_byte = step_byte;
                  rsp_word_in.item_last   = step_last;
                  rsp_word_in.final_flush = 1'b0;
               end
               if (step_ff == 2'd3) begin
                  state_in = item_ff.stream_end ? ST_FLUSH : ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            // Eight packed bits always leave slots in use, so a flush emits.
            if (out_free) begin
               push                    = 1'b1;
               rsp_word_in.serial_byte = win_ff[8:1];
               rsp_word_in.item_last   = 1'b1;
               rsp_word_in.final_flush = 1'b1;
               win_in                  = WINDOW_ONES;
               used_in                 = 4'd0;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (take) begin
         item_in  = queue_entry;
         step_in  = 2'd0;
         state_in = ST_PACK;
      end
   end

   // Output register: loaded on a push, cleared once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= 2'd0;
         win_ff       <= WINDOW_ONES;
         used_ff      <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         win_ff       <= win_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_word_ff <= rsp_word_in;
   end

   // A push never overwrites a word that the receiver has not taken.
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("result pushed into an occupied output register");

   // The fill count never passes the window size.
   a_used_range: assert property (@(posedge clock) disable iff (reset)
      used_ff <= 4'(WINDOW_SLOTS))
      else $error("slot count beyond window size");

   // A flush always has slots to emit.
   a_flush_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> (used_ff != 4'd0))
      else $error("flush with an empty window");

   // After a flush the window starts over all high and empty.
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FLUSH) && out_free) |=> ((win_ff == WINDOW_ONES) && (used_ff == 4'd0)))
      else $error("window not cleared after flush");

endmodule

FILE: design/pulse_width_bit_packer.sv
// ---------------------------------------------------------------------------
// Pulse width bit packer
// Encodes data bytes as pulse-width slot codes packed into serial bytes.
// ---------------------------------------------------------------------------
// Usage: words enter on the req_ channel (req_valid, req_stall, req_data) and
// packed serial bytes leave on the rsp_ channel (rsp_valid, rsp_stall,
// rsp_data). A word is taken at a clock edge where valid is high and stall is
// low. Each input byte is packed two bits a cycle by the back while the
// output is free, followed by a flush of the window when stream_end is set.
// An input word causes zero to four result words; item_last marks the last
// of them and final_flush marks the flushed window that ends a stream.
// A taken word is held in the queue and the back's item register before its
// first result is registered. A queue of QUEUE_DEPTH words between front
// and back takes new words while the back is busy; req_stall is its full flag.
// When rsp_stall is held the back halts on its current bit pair, the output
// word holds, and the queue then fills and stalls the input side.
// Synchronous reset empties the queue and output register and restarts the
// slot window all high and empty. There are no configuration registers.
// ---------------------------------------------------------------------------
module pulse_width_bit_packer #(
   parameter int unsigned QUEUE_DEPTH = pwbp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pwbp_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pwbp_pkg::rsp_word_type rsp_data
);
   import pwbp_pkg::*;

   logic            push_valid;
   queue_entry_type push_entry;
   logic            queue_full;
   logic            queue_pop;
   logic            queue_valid;
   queue_entry_type queue_entry;

   // Front: accept and classify input words.
   pwbp_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   // Queue between front and back.
   pwbp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .pop_valid  (queue_valid),
      .pop_entry  (queue_entry)
   );

   // Back: slot packing and result output.
   pwbp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_valid (queue_valid),
      .queue_entry (queue_entry),
      .queue_pop   (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
